/* hdl/prs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared types, widths and pose tables for the pose ramp sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int ANGLE_W = 16;
    localparam int VEL_W   = 24;
    localparam int DUR_W   = 26;
    localparam int PER_W   = 16;
    localparam int NUM_W   = 44;
    localparam int JIDX_W  = 4;

    localparam logic [DUR_W-1:0] DUR_RESET   = 26'd2000000;
    localparam logic [DUR_W-1:0] ELAPSED_MAX = 26'h3FFFFFF;
    localparam logic [19:0]      US_PER_S    = 20'd1000000;

    typedef enum logic [1:0] {
        PH_STAT  = 2'd0,
        PH_RAISE = 2'd1,
        PH_LOWER = 2'd2
    } t_phase;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    // one memory word per joint
    typedef struct packed {
        logic signed [ANGLE_W-1:0] start;
        logic signed [ANGLE_W-1:0] prev;
        logic signed [ANGLE_W-1:0] cur;
    } t_joint_word;

    function automatic logic signed [ANGLE_W-1:0] f_stand(input logic [JIDX_W-1:0] j);
        logic signed [ANGLE_W-1:0] r;
        case (j)
            4'd1, 4'd4, 4'd7, 4'd10: r = 16'sd2744;
            4'd2, 4'd3, 4'd8, 4'd9:  r = -16'sd5325;
            default:                 r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] f_sit(input logic [JIDX_W-1:0] j);
        logic signed [ANGLE_W-1:0] r;
        case (j)
            4'd1, 4'd4, 4'd7, 4'd10: r = 16'sd5571;
            4'd2, 4'd3, 4'd8, 4'd9:  r = -16'sd10854;
            4'd5:                    r = 16'sd819;
            4'd6:                    r = -16'sd819;
            default:                 r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/prs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module prs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                          i_wdata,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/prs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prs_div
    import prs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DUR_W-1:0]  i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DUR_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], w_ge};
                r_rem <= w_ge ? DUR_W'(w_trial - {1'b0, r_den}) : w_trial[DUR_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

/* hdl/pose_ramp_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_ramp_sequencer
// Ramps joint position references between a captured pose and fixed poses.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tuser mode, tdata capture/tick fields
//  m_axis    out  tvalid/tready, tlast   tdata one joint reference
//  cfg       in   we                     wdata ramp_duration_us
//
//  a capture writes the joint memory from idle; a ramping tick makes two
//  passes of the shared bit-serial divider per joint (position, then
//  velocity); a holding tick makes one pass per joint, for velocity only
//  joint state sits in one 48-bit memory, read-modify-write per joint
//  a stalled output holds the sequencer before the next joint is loaded
//  synchronous active-low reset; joint memory is not cleared
// ----------------------------------------------------------------------------
module pose_ramp_sequencer
    import prs_pkg::*;
#(
    parameter int NUM_JOINTS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // joint_index[3:0], joint_position[19:4], raise_request[20],
    // lower_request[21], period_us[37:22], zero fill
    input  logic [39:0] i_s_axis_tdata,
    // mode[0]
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_joint[3:0], position_ref[19:4], velocity_ref[43:20],
    // motion_phase[45:44], zero fill
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [25:0] i_cfg_wdata
);
    localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int AW = JW;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_LOAD, S_MUL, S_PWAIT, S_VMUL, S_VWAIT, S_EMIT
    } t_state;

    t_state                     r_state;
    t_phase                     r_phase;
    logic [DUR_W-1:0]           r_elapsed;
    logic [DUR_W-1:0]           r_dur;
    logic [PER_W-1:0]           r_period;
    logic                       r_ramp;
    logic                       r_fin;
    logic                       r_sit;
    logic [JW-1:0]              r_j;
    t_joint_word                r_word;
    logic signed [ANGLE_W:0]    r_diff;
    logic [NUM_W-1:0]           r_num;
    logic                       r_neg;
    logic                       r_div_go;
    logic [DUR_W-1:0]           r_den;
    logic signed [VEL_W-1:0]    r_vel;
    logic                       r_out_valid;
    logic [47:0]                r_out_data;
    logic                       r_out_last;

    // input fields
    logic                       w_mode;
    logic [JIDX_W-1:0]          w_jidx;
    logic signed [ANGLE_W-1:0]  w_pos;
    logic                       w_raise;
    logic                       w_lower;
    logic [PER_W-1:0]           w_per;
    logic                       w_acc;

    assign w_mode  = i_s_axis_tuser[0];
    assign w_jidx  = i_s_axis_tdata[3:0];
    assign w_pos   = i_s_axis_tdata[19:4];
    assign w_raise = i_s_axis_tdata[20];
    assign w_lower = i_s_axis_tdata[21];
    assign w_per   = i_s_axis_tdata[37:22];
    assign w_acc   = i_s_axis_tvalid && o_s_axis_tready;

    logic w_cap_ok;
    assign w_cap_ok = ({1'b0, w_jidx} < 5'(NUM_JOINTS));

    // tick phase/time update
    logic                       w_was;
    t_phase                     w_ph;
    logic [DUR_W-1:0]           w_el;
    logic [DUR_W:0]             w_sum;
    logic                       w_lt;

    always_comb begin
        w_was = (r_phase == PH_RAISE) || (r_phase == PH_LOWER);
        w_sum = {1'b0, r_elapsed} + (DUR_W+1)'(w_per);
        w_ph  = r_phase;
        w_el  = r_elapsed;
        if (!w_was) begin
            if (w_raise) begin
                w_ph = PH_RAISE;
                w_el = '0;
            end else if (w_lower) begin
                w_ph = PH_LOWER;
                w_el = '0;
            end else begin
                w_ph = PH_STAT;
            end
        end else begin
            w_el = w_sum[DUR_W] ? ELAPSED_MAX : w_sum[DUR_W-1:0];
        end
        w_lt = (w_el < r_dur);
    end

    // memory
    logic                       w_we;
    logic [AW-1:0]              w_addr;
    t_joint_word                w_wdata;
    t_joint_word                w_rdata;
    logic                       w_slot;
    logic signed [ANGLE_W-1:0]  w_tgt;
    logic signed [ANGLE_W-1:0]  w_newstart;

    assign w_slot     = !r_out_valid || i_m_axis_tready;
    assign w_tgt      = r_sit ? f_sit(JIDX_W'(r_j)) : f_stand(JIDX_W'(r_j));
    assign w_newstart = r_fin ? w_tgt : r_word.start;

    always_comb begin
        w_we    = 1'b0;
        w_addr  = AW'(r_j);
        w_wdata = '{start: w_newstart, prev: r_word.cur, cur: r_word.cur};
        if (r_state == S_IDLE) begin
            w_addr  = AW'(w_jidx[JW-1:0]);
            w_we    = w_acc && (w_mode == MODE_CAPTURE) && w_cap_ok;
            w_wdata = '{start: w_pos, prev: w_pos, cur: w_pos};
        end else if (r_state == S_EMIT) begin
            w_we = w_slot;
        end
    end

    prs_ram #(.WIDTH($bits(t_joint_word)), .DEPTH(NUM_JOINTS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    logic               w_div_done;
    logic [NUM_W-1:0]   w_quot;

    prs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // datapath helpers
    logic [ANGLE_W:0]           w_dmag;
    logic signed [ANGLE_W:0]    w_vd;
    logic [ANGLE_W:0]           w_vmag;
    logic signed [ANGLE_W:0]    w_step;
    logic signed [ANGLE_W:0]    w_pnew;
    logic signed [VEL_W-1:0]    w_vsat;

    always_comb begin
        w_dmag = r_diff[ANGLE_W] ? (ANGLE_W+1)'(-r_diff) : r_diff;
        w_vd   = (ANGLE_W+1)'(r_word.cur) - (ANGLE_W+1)'(r_word.prev);
        w_vmag = w_vd[ANGLE_W] ? (ANGLE_W+1)'(-w_vd) : w_vd;
        w_step = r_neg ? (ANGLE_W+1)'(-w_quot[ANGLE_W:0]) : w_quot[ANGLE_W:0];
        w_pnew = (ANGLE_W+1)'(r_word.start) + w_step;
        if (r_neg) begin
            w_vsat = (w_quot > NUM_W'(24'h800000)) ? 24'sh800000
                                                  : VEL_W'(-w_quot[VEL_W-1:0]);
        end else begin
            w_vsat = (w_quot > NUM_W'(24'h7FFFFF)) ? 24'sh7FFFFF : w_quot[VEL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_STAT;
            r_elapsed   <= '0;
            r_dur       <= DUR_RESET;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
            r_j         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dur <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_axis_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (w_mode == MODE_CAPTURE) begin
                            if (w_cap_ok) begin
                                r_phase   <= PH_STAT;
                                r_elapsed <= '0;
                            end
                        end else begin
                            r_elapsed <= w_el;
                            r_ramp    <= (w_ph != PH_STAT) && w_lt;
                            r_fin     <= (w_ph != PH_STAT) && !w_lt;
                            r_phase   <= ((w_ph != PH_STAT) && !w_lt) ? PH_STAT : w_ph;
                            r_sit     <= (w_ph == PH_LOWER);
                            r_period  <= (w_per == '0) ? PER_W'(1) : w_per;
                            r_j       <= '0;
                            r_state   <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_word  <= w_rdata;
                    r_diff  <= (ANGLE_W+1)'(w_tgt) - (ANGLE_W+1)'(w_rdata.start);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_ramp) begin
                        r_num    <= NUM_W'(w_dmag) * NUM_W'(r_elapsed);
                        r_neg    <= r_diff[ANGLE_W];
                        r_den    <= r_dur;
                        r_div_go <= 1'b1;
                        r_state  <= S_PWAIT;
                    end else begin
                        if (!r_fin) begin
                            r_word.cur <= r_word.start;
                        end
                        r_state <= S_VMUL;
                    end
                end
                S_PWAIT: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_word.cur <= w_pnew[ANGLE_W-1:0];
                        r_state    <= S_VMUL;
                    end
                end
                S_VMUL: begin
                    r_num    <= NUM_W'(w_vmag) * NUM_W'(US_PER_S);
                    r_neg    <= w_vd[ANGLE_W];
                    r_den    <= DUR_W'(r_period);
                    r_div_go <= 1'b1;
                    r_state  <= S_VWAIT;
                end
                S_VWAIT: begin
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_vel   <= w_vsat;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'b00, r_phase, r_vel, r_word.cur, JIDX_W'(r_j)};
                        r_out_last  <= (r_j == JW'(NUM_JOINTS - 1));
                        if (r_j == JW'(NUM_JOINTS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    a_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tdata[3:0] == 4'(NUM_JOINTS - 1)))
        else $error("tlast on a joint other than the final one");

    a_capture_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_mode == MODE_CAPTURE) && w_cap_ok)
            |=> (r_phase == PH_STAT && r_elapsed == '0))
        else $error("capture did not clear phase and elapsed time");

    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_PWAIT || r_state == S_VWAIT))
        else $error("divider finished outside a wait state");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE || r_state == S_EMIT))
        else $error("joint memory written mid computation");
endmodule
